// File: rtl/core/bhw_pkg.sv
// ----------------------------------------------------------------------------
// bhw_pkg
// Shared constants, types and helpers of the BMP hit-count image writer.
// ----------------------------------------------------------------------------
package bhw_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int DIM_W  = 13;
  localparam int CNT_W  = 12;
  localparam int HITS_W = 32;
  localparam int GAIN_W = 24;
  localparam int OFS_W  = 11;
  localparam int BYTE_W = 8;
  localparam int SUM_W  = HITS_W + 2;
  localparam int MAG_W  = 24;
  localparam int BODY_W = 32;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int QUSE_W = QCNT_W + 1;

  localparam int HDR_LEN = 54;
  localparam int IDX_W   = 6;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_OFFSET = 3'd2;
  localparam logic [2:0] REG_RGAIN  = 3'd3;
  localparam logic [2:0] REG_GGAIN  = 3'd4;
  localparam logic [2:0] REG_BGAIN  = 3'd5;

  localparam logic [DIM_W-1:0]         RST_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0]         RST_HEIGHT = 13'd1080;
  localparam logic signed [OFS_W-1:0]  RST_OFFSET = -11'sd230;
  localparam logic [GAIN_W-1:0]        RST_RGAIN  = 24'd5898;
  localparam logic [GAIN_W-1:0]        RST_GGAIN  = 24'd7209;
  localparam logic [GAIN_W-1:0]        RST_BGAIN  = 24'd11796;

  localparam logic [7:0]  HDR_SIG0      = 8'h42;
  localparam logic [7:0]  HDR_SIG1      = 8'h4D;
  localparam logic [7:0]  HDR_PLANES    = 8'd1;
  localparam logic [7:0]  HDR_BPP       = 8'd24;
  localparam logic [31:0] HDR_DATA_OFS  = 32'd54;
  localparam logic [31:0] HDR_INFO_SIZE = 32'd40;

  // channel order inside a pixel: blue, green, red
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  typedef struct packed {
    logic [DIM_W-1:0]        width;
    logic [DIM_W-1:0]        height;
    logic signed [OFS_W-1:0] offset;
    logic [2:0][GAIN_W-1:0]  gain;
  } cfg_t;

  typedef struct packed {
    logic                   hdr;
    logic [1:0]             pad;
    logic [2:0][BYTE_W-1:0] chan;
  } entry_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input int maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > maxv) begin
      r = DIM_W'(maxv);
    end
    return r;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                          input logic [DIM_W-1:0] w,
                                          input logic [DIM_W-1:0] h,
                                          input logic [BODY_W-1:0] body,
                                          input logic [BODY_W-1:0] fsize);
    logic [31:0] word;
    logic [1:0]  sel;
    logic [7:0]  b;
    word = '0;
    sel  = idx[1:0] ^ 2'b10;
    case (idx)
      6'd2, 6'd3, 6'd4, 6'd5:     word = fsize;
      6'd10, 6'd11, 6'd12, 6'd13: word = HDR_DATA_OFS;
      6'd14, 6'd15, 6'd16, 6'd17: word = HDR_INFO_SIZE;
      6'd18, 6'd19, 6'd20, 6'd21: word = 32'(w);
      6'd22, 6'd23, 6'd24, 6'd25: word = 32'(h);
      6'd34, 6'd35, 6'd36, 6'd37: word = body;
      default:                    word = '0;
    endcase
    b = 8'(word >> {sel, 3'b000});
    case (idx)
      6'd0:    b = HDR_SIG0;
      6'd1:    b = HDR_SIG1;
      6'd26:   b = HDR_PLANES;
      6'd28:   b = HDR_BPP;
      default: b = b;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/bhw_pixel_if.sv
// ----------------------------------------------------------------------------
// bhw_pixel_if
// Pixel channel: three hit counts per transaction.
// ----------------------------------------------------------------------------
interface bhw_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] red_hits;
  logic [31:0] green_hits;
  logic [31:0] blue_hits;

  modport source (output valid, red_hits, green_hits, blue_hits, input ready);
  modport sink   (input valid, red_hits, green_hits, blue_hits, output ready);
endinterface

// File: rtl/core/bhw_byte_if.sv
// ----------------------------------------------------------------------------
// bhw_byte_if
// File byte channel: one byte of the BMP stream per transaction.
// ----------------------------------------------------------------------------
interface bhw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       run_last;

  modport source (output valid, file_byte, run_last, input ready);
  modport sink   (input valid, file_byte, run_last, output ready);
endinterface

// File: rtl/core/bhw_front.sv
// ----------------------------------------------------------------------------
// bhw_front
// Accepts pixels, tracks row/column position, scales the three channels.
// ----------------------------------------------------------------------------
module bhw_front (
  input  logic                          clk,
  input  logic                          rst,
  input  bhw_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0][bhw_pkg::HITS_W-1:0] in_hits,
  input  logic [bhw_pkg::QCNT_W-1:0]    q_count,
  output logic                          push,
  output bhw_pkg::entry_t               push_entry
);
  import bhw_pkg::*;

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;

  logic                  a_valid;
  logic                  a_hdr;
  logic [1:0]            a_pad;
  logic [2:0][MAG_W-1:0] a_mag;
  logic [2:0]            a_neg;

  logic   b_valid;
  entry_t b_entry;

  logic [QUSE_W-1:0]     used;
  logic                  accept;
  logic                  row_end;
  logic                  frame_end;
  logic [2:0][SUM_W-1:0] sum;
  logic [2:0][BYTE_W-1:0] prod_byte;

  assign used     = QUSE_W'(q_count) + QUSE_W'(a_valid) + QUSE_W'(b_valid);
  assign in_ready = used < QUSE_W'(QDEPTH);
  assign accept   = in_valid && in_ready;

  assign row_end   = ({1'b0, column_count} + DIM_W'(1)) >= cfg.width;
  assign frame_end = ({1'b0, row_count} + DIM_W'(1)) >= cfg.height;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = {2'b00, in_hits[c]} + SUM_W'(cfg.offset);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
    if (accept) begin
      a_hdr <= (column_count == '0) && (row_count == '0);
      a_pad <= row_end ? cfg.width[1:0] : 2'b00;
      for (int c = 0; c < 3; c++) begin
        a_neg[c] <= sum[c][SUM_W-1];
        a_mag[c] <= sum[c][SUM_W-1] ? MAG_W'(-sum[c]) : sum[c][MAG_W-1:0];
      end
    end
  end

  // low byte of the truncated quotient sits at product bits [23:16]
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_byte[c] = 8'((48'(a_mag[c]) * 48'(cfg.gain[c])) >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    if (a_valid) begin
      b_entry.hdr <= a_hdr;
      b_entry.pad <= a_pad;
      for (int c = 0; c < 3; c++) begin
        b_entry.chan[c] <= a_neg[c] ? 8'(-prod_byte[c]) : prod_byte[c];
      end
    end
  end

  assign push       = b_valid;
  assign push_entry = b_entry;

endmodule

// File: rtl/core/bhw_queue.sv
// ----------------------------------------------------------------------------
// bhw_queue
// Short FIFO of scaled pixels between front and back.
// ----------------------------------------------------------------------------
module bhw_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  bhw_pkg::entry_t            push_entry,
  input  logic                       pop,
  output logic                       head_valid,
  output bhw_pkg::entry_t            head,
  output logic [bhw_pkg::QCNT_W-1:0] count
);
  import bhw_pkg::*;

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;

  assign head_valid = count != '0;
  assign head       = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

endmodule

// File: rtl/core/bhw_back.sv
// ----------------------------------------------------------------------------
// bhw_back
// Serializes header, pixel bytes and row padding into the byte stream.
// ----------------------------------------------------------------------------
module bhw_back (
  input  logic              clk,
  input  logic              rst,
  input  bhw_pkg::cfg_t     cfg,
  input  logic              head_valid,
  input  bhw_pkg::entry_t   head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import bhw_pkg::*;

  localparam logic [1:0] ST_START = 2'd0;
  localparam logic [1:0] ST_HDR   = 2'd1;
  localparam logic [1:0] ST_PIX   = 2'd2;
  localparam logic [1:0] ST_PAD   = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  logic [BODY_W-1:0] body;
  logic [BODY_W-1:0] fsize;

  logic [1:0]       ph;
  logic [IDX_W-1:0] ix;
  logic             load;
  logic [7:0]       byte_val;
  logic             last_val;

  always_ff @(posedge clk) begin
    body  <= BODY_W'((15'(cfg.width) * 15'd3 + 15'(cfg.width[1:0])) *
                     BODY_W'(cfg.height));
    fsize <= body + BODY_W'(HDR_LEN);
  end

  assign load = head_valid && (!out_valid || out_ready);

  always_comb begin
    ph = state;
    ix = idx;
    if (state == ST_START) begin
      ph = head.hdr ? ST_HDR : ST_PIX;
      ix = '0;
    end
    byte_val   = 8'h00;
    last_val   = 1'b0;
    state_next = ph;
    idx_next   = ix + IDX_W'(1);
    case (ph)
      ST_HDR: begin
        byte_val = hdr_byte(ix, cfg.width, cfg.height, body, fsize);
        if (ix == IDX_W'(HDR_LEN - 1)) begin
          state_next = ST_PIX;
          idx_next   = '0;
        end
      end
      ST_PIX: begin
        byte_val = head.chan[ix[1:0]];
        if (ix == IDX_W'(2)) begin
          idx_next = '0;
          if (head.pad != 2'b00) begin
            state_next = ST_PAD;
          end else begin
            state_next = ST_START;
            last_val   = 1'b1;
          end
        end
      end
      ST_PAD: begin
        if (ix[1:0] == head.pad - 2'd1) begin
          state_next = ST_START;
          idx_next   = '0;
          last_val   = 1'b1;
        end
      end
      default: begin
        state_next = ST_START;
        idx_next   = '0;
      end
    endcase
  end

  assign pop = load && last_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_START;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        state     <= state_next;
        idx       <= idx_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (load) begin
      out_byte <= byte_val;
      out_last <= last_val;
    end
  end

endmodule

// File: rtl/core/bmp_hit_count_image_writer.sv
// ----------------------------------------------------------------------------
// bmp_hit_count_image_writer
// Streams a 24-bit bottom-up BMP file from per-pixel hit counts.
//
// pixel:    one transaction per pixel (red/green/blue hit counts), in file
//           order: bottom row first, left to right.
// file_out: one file byte per transaction; run_last marks the final byte
//           produced by a pixel.
// APB:      width, height, count offset and the three Q8.16 gains at byte
//           addresses 0x00..0x14. Write only while the stream is idle.
// Path:     a pixel passes the front's a and b registers, then the queue, and
//           its first byte appears from the output register.
// Throughput: one byte per cycle from the output serializer while a pixel is
//           queued and the receiver is ready, i.e. three bytes per pixel, plus
//           54 header bytes ahead of a frame's first pixel and 0..3 pad bytes
//           at each row end. A 4-entry queue takes pixels while bytes drain.
// Reset:    registers take their defaults, position counters clear so the
//           next pixel opens a new file with a header.
// A stalled receiver holds the current byte; once queued plus in-flight
// front pixels reach the queue depth, the pixel channel deasserts ready.
// ----------------------------------------------------------------------------
module bmp_hit_count_image_writer (
  input  logic                        clk,
  input  logic                        rst,
  bhw_pixel_if.sink                   pixel,
  bhw_byte_if.source                  file_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bhw_pkg::APB_AW-1:0]  paddr,
  input  logic [bhw_pkg::APB_DW-1:0]  pwdata,
  output logic [bhw_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import bhw_pkg::*;

  logic [DIM_W-1:0]        image_width;
  logic [DIM_W-1:0]        image_height;
  logic signed [OFS_W-1:0] count_offset;
  logic [GAIN_W-1:0]       red_gain;
  logic [GAIN_W-1:0]       green_gain;
  logic [GAIN_W-1:0]       blue_gain;

  cfg_t                    cfg;
  logic [2:0][HITS_W-1:0]  hits;
  logic                    push;
  entry_t                  push_entry;
  logic                    pop;
  logic                    head_valid;
  entry_t                  head;
  logic [QCNT_W-1:0]       q_count;
  logic                    wr_en;
  logic [2:0]              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
      count_offset <= RST_OFFSET;
      red_gain     <= RST_RGAIN;
      green_gain   <= RST_GGAIN;
      blue_gain    <= RST_BGAIN;
    end else if (wr_en) begin
      case (reg_sel)
        REG_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        REG_OFFSET: count_offset <= pwdata[OFS_W-1:0];
        REG_RGAIN:  red_gain     <= pwdata[GAIN_W-1:0];
        REG_GGAIN:  green_gain   <= pwdata[GAIN_W-1:0];
        REG_BGAIN:  blue_gain    <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = APB_DW'(image_width);
      REG_HEIGHT: prdata = APB_DW'({count_offset[0], image_height} & {1'b0, {DIM_W{1'b1}}});
      REG_OFFSET: prdata = APB_DW'(count_offset[OFS_W-1:0]);
      REG_RGAIN:  prdata = APB_DW'(red_gain);
      REG_GGAIN:  prdata = APB_DW'(green_gain);
      REG_BGAIN:  prdata = APB_DW'(blue_gain);
      default:    prdata = '0;
    endcase
  end

  assign cfg.width          = eff_dim(image_width, MAX_WIDTH);
  assign cfg.height         = eff_dim(image_height, MAX_HEIGHT);
  assign cfg.offset         = count_offset;
  assign cfg.gain[CH_BLUE]  = blue_gain;
  assign cfg.gain[CH_GREEN] = green_gain;
  assign cfg.gain[CH_RED]   = red_gain;

  assign hits[CH_BLUE]  = pixel.blue_hits;
  assign hits[CH_GREEN] = pixel.green_hits;
  assign hits[CH_RED]   = pixel.red_hits;

  bhw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (pixel.valid),
    .in_ready   (pixel.ready),
    .in_hits    (hits),
    .q_count    (q_count),
    .push       (push),
    .push_entry (push_entry)
  );

  bhw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  bhw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (file_out.valid),
    .out_ready  (file_out.ready),
    .out_byte   (file_out.file_byte),
    .out_last   (file_out.run_last)
  );

endmodule

// File: tb/bhw_tb_pkg.sv
// ----------------------------------------------------------------------------
// bhw_tb_pkg
// Scoreboard for the BMP hit-count image writer: predicts the file byte
// stream (header, scaled channel bytes, row padding) from each accepted pixel
// and the register settings, and checks every file byte against it in order.
// ----------------------------------------------------------------------------
package bhw_tb_pkg;
  import bhw_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } file_byte_t;

  class bmp_stream_scoreboard;
    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;
    logic signed [OFS_W-1:0] offset_reg;
    logic [GAIN_W-1:0]       red_gain_reg;
    logic [GAIN_W-1:0]       green_gain_reg;
    logic [GAIN_W-1:0]       blue_gain_reg;
    int unsigned             column_pos;
    int unsigned             row_pos;
    file_byte_t              file_bytes[$];
    int                      errors;

    function new();
      width_reg      = 13'd1920;
      height_reg     = 13'd1080;
      offset_reg     = -11'sd230;
      red_gain_reg   = 24'd5898;
      green_gain_reg = 24'd7209;
      blue_gain_reg  = 24'd11796;
      column_pos     = 0;
      row_pos        = 0;
      errors         = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_WIDTH:  width_reg      = value[DIM_W-1:0];
        REG_HEIGHT: height_reg     = value[DIM_W-1:0];
        REG_OFFSET: offset_reg     = value[OFS_W-1:0];
        REG_RGAIN:  red_gain_reg   = value[GAIN_W-1:0];
        REG_GGAIN:  green_gain_reg = value[GAIN_W-1:0];
        REG_BGAIN:  blue_gain_reg  = value[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
    endfunction

    // (hits + offset) * gain in Q8.16, truncated toward zero, low byte
    function logic [7:0] scale_channel(logic [31:0] hits, logic [GAIN_W-1:0] gain);
      longint          total;
      longint unsigned mag;
      longint unsigned scaled;
      total  = $signed({32'd0, hits}) + offset_reg;
      mag    = (total < 0) ? -total : total;
      scaled = (mag * gain) >> 16;
      if (total < 0) scaled = -scaled;
      return scaled[7:0];
    endfunction

    function void push_byte(logic [7:0] data);
      file_bytes.push_back('{data, 1'b0});
    endfunction

    function void push_word(logic [31:0] word);
      for (int i = 0; i < 4; i++) push_byte(word[8*i +: 8]);
    endfunction

    function void note_pixel(logic [31:0] red, logic [31:0] green, logic [31:0] blue);
      int unsigned w;
      int unsigned h;
      int unsigned pad;
      int unsigned body;
      file_byte_t  tail;
      w   = clamp_dim(width_reg, MAX_WIDTH);
      h   = clamp_dim(height_reg, MAX_HEIGHT);
      pad = (4 - (w * 3) % 4) % 4;
      if (column_pos == 0 && row_pos == 0) begin
        body = (w * 3 + pad) * h;
        push_byte(8'h42);
        push_byte(8'h4D);
        push_word(body + 54);
        push_word(0);
        push_word(54);
        push_word(40);
        push_word(w);
        push_word(h);
        push_byte(8'd1);
        push_byte(8'd0);
        push_byte(8'd24);
        push_byte(8'd0);
        push_word(0);
        push_word(body);
        repeat (4) push_word(0);
      end
      push_byte(scale_channel(blue, blue_gain_reg));
      push_byte(scale_channel(green, green_gain_reg));
      push_byte(scale_channel(red, red_gain_reg));
      if (column_pos + 1 >= w) begin
        repeat (pad) push_byte(8'd0);
        column_pos = 0;
        row_pos    = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
        column_pos++;
      end
      tail      = file_bytes.pop_back();
      tail.last = 1'b1;
      file_bytes.push_back(tail);
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      file_byte_t exp_b;
      if (file_bytes.size() == 0) begin
        $error("unexpected file byte 0x%02h run_last %0b", data, last);
        errors++;
        return;
      end
      exp_b = file_bytes.pop_front();
      if (data !== exp_b.data) begin
        $error("file_byte: expected 0x%02h, got 0x%02h", exp_b.data, data);
        errors++;
      end
      if (last !== exp_b.last) begin
        $error("run_last: expected %0b, got %0b", exp_b.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives pixels into the BMP hit-count image writer with random idling on
// both channels, reprograms geometry, offset and gains over APB between
// bursts (extremes, zero and oversized sizes, mid-frame changes), and checks
// the byte stream against the scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bhw_pkg::*;
  import bhw_tb_pkg::*;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              steady;
  int                pixels_sent;

  bmp_stream_scoreboard board;

  bhw_pixel_if pix ();
  bhw_byte_if  fout ();

  bmp_hit_count_image_writer i_dut (
    .clk      (clk),
    .rst      (rst),
    .pixel    (pix),
    .file_out (fout),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    fout.ready <= steady || ($urandom_range(0, 99) >= 21);
    if (!rst && fout.valid && fout.ready) begin
      board.check_byte(fout.file_byte, fout.run_last);
    end
  end

  task automatic program_regs(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [OFS_W-1:0] ofs, input logic [GAIN_W-1:0] rg,
                              input logic [GAIN_W-1:0] gg, input logic [GAIN_W-1:0] bg);
    logic [31:0] values [6];
    logic [2:0]  regs [6];
    values = '{32'(w), 32'(h), 32'(ofs), 32'(rg), 32'(gg), 32'(bg)};
    regs   = '{REG_WIDTH, REG_HEIGHT, REG_OFFSET, REG_RGAIN, REG_GGAIN, REG_BGAIN};
    for (int i = 0; i < 6; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {regs[i], 2'b00};
      pwdata  <= values[i];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      board.write_reg(regs[i], values[i]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_pixel(input logic [31:0] red, input logic [31:0] green,
                            input logic [31:0] blue);
    if (!steady && $urandom_range(0, 99) < 21) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid      <= 1'b1;
    pix.red_hits   <= red;
    pix.green_hits <= green;
    pix.blue_hits  <= blue;
    do @(posedge clk); while (!pix.ready);
    board.note_pixel(red, green, blue);
    pixels_sent++;
  endtask

  // hold the pixel channel until every predicted byte has come out
  task automatic drain_stream();
    pix.valid <= 1'b0;
    while (board.file_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_hits();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 2047);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] random_dim(input int unsigned common_max);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIM_W'($urandom_range(4097, 8191));
      2:       return DIM_W'($urandom_range(1, 8191));
      default: return DIM_W'($urandom_range(1, common_max));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 24'hFF_FFFF;
      2:       return GAIN_W'($urandom_range(0, 24'h01_FFFF));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  initial begin
    board          = new();
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    pix.valid      = 1'b0;
    pix.red_hits   = '0;
    pix.green_hits = '0;
    pix.blue_hits  = '0;
    steady         = 1'b0;
    pixels_sent    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset geometry 1920x1080, negative, zero and huge sums
    send_pixel(32'd0, 32'd0, 32'd0);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(32'd230, 32'd230, 32'd230);
    send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF);
    drain_stream();

    // zero sizes read as 1x1: every pixel is a whole file
    program_regs('0, '0, 11'h400, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    send_pixel(32'd0, 32'd0, 32'd0);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(32'd1023, 32'd1024, 32'd1025);
    drain_stream();

    // oversized sizes saturate
    program_regs(13'h1FFF, 13'h1FFF, 11'h3FF, 24'h00_0000, 24'h00_0001, 24'h01_0000);
    repeat (3) send_pixel(random_hits(), random_hits(), random_hits());
    drain_stream();

    // shrink mid-frame: the open row ends at once
    program_regs(13'd2, 13'd3, 11'h000, 24'h00_8000, 24'h02_0000, 24'h12_3456);
    repeat (7) send_pixel(random_hits(), random_hits(), random_hits());
    drain_stream();

    program_regs(13'd4096, 13'd4096, -11'sd230, 24'h00_0100, 24'hFF_FFFF, 24'h00_0000);
    repeat (2) send_pixel(random_hits(), random_hits(), random_hits());
    drain_stream();

    for (int phase = 0; pixels_sent < 215; phase++) begin
      int               burst;
      logic [OFS_W-1:0] ofs;
      case ($urandom_range(0, 4))
        0:       ofs = 11'h400;
        1:       ofs = 11'h3FF;
        default: ofs = OFS_W'($urandom);
      endcase
      program_regs(random_dim(7), random_dim(4), ofs, random_gain(), random_gain(),
                   random_gain());
      steady <= (phase == 2);
      burst = (phase == 2) ? 40 : $urandom_range(12, 36);
      repeat (burst) send_pixel(random_hits(), random_hits(), random_hits());
      drain_stream();
    end

    repeat (16) @(posedge clk);
    if (board.errors == 0 && board.file_bytes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/core/bhw_pkg.sv
rtl/core/bhw_pixel_if.sv
rtl/core/bhw_byte_if.sv
rtl/core/bhw_front.sv
rtl/core/bhw_queue.sv
rtl/core/bhw_back.sv
rtl/core/bmp_hit_count_image_writer.sv
tb/bhw_tb_pkg.sv
tb/testbench.sv
